// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the line matcher RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/slm_pkg.sv =====
// Shared types and constants of the regex line matcher.
// No dependencies.
`default_nettype none

package slm_pkg;

    // Largest number of pattern elements supported
    localparam int PATTERN_MAX_DEF = 12;

    // Field widths
    localparam int ELEM_W     = 10;
    localparam int HALF_W     = 60;
    localparam int PAT_W      = 2 * HALF_W;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int COUNT_W    = 32;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 3'd0,
        CFG_PATTERN_HIGH   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_ANCHOR_START   = 3'd3,
        CFG_ANCHOR_END     = 3'd4
    } t_cfg_idx;

    // One pattern element: starred bit 9, any-char bit 8, literal char 7:0
    typedef struct packed {
        logic       star;
        logic       any;
        logic [7:0] ch;
    } t_elem;

    // Configuration as seen by the matcher core
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] length;
        logic             anchor_start;
        logic             anchor_end;
    } t_cfg;

    // Per-item flags out of the NFA step
    typedef struct packed {
        logic found;
        logic hit;
    } t_step_flags;

endpackage

`default_nettype wire

// ===== rtl/slm_cfg_regs.sv =====
// Configuration register file of the regex line matcher.
// Depends on slm_pkg.
`default_nettype none

module slm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output slm_pkg::t_cfg                       o_cfg
);

    logic [slm_pkg::HALF_W-1:0] r_pat_low;
    logic [slm_pkg::HALF_W-1:0] r_pat_high;
    logic [slm_pkg::LEN_W-1:0]  r_length;
    logic                       r_anchor_start;
    logic                       r_anchor_end;

    assign o_cfg_ready = 1'b1;

    // Register writes, one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low      <= '0;
            r_pat_high     <= '0;
            r_length       <= '0;
            r_anchor_start <= 1'b0;
            r_anchor_end   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (slm_pkg::t_cfg_idx'(i_cfg_index))
                slm_pkg::CFG_PATTERN_LOW:    r_pat_low      <= i_cfg_data;
                slm_pkg::CFG_PATTERN_HIGH:   r_pat_high     <= i_cfg_data;
                slm_pkg::CFG_PATTERN_LENGTH: r_length       <= i_cfg_data[slm_pkg::LEN_W-1:0];
                slm_pkg::CFG_ANCHOR_START:   r_anchor_start <= i_cfg_data[0];
                slm_pkg::CFG_ANCHOR_END:     r_anchor_end   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.pattern      = {r_pat_high, r_pat_low};
    assign o_cfg.length       = r_length;
    assign o_cfg.anchor_start = r_anchor_start;
    assign o_cfg.anchor_end   = r_anchor_end;

endmodule

`default_nettype wire

// ===== rtl/slm_nfa_step.sv =====
// One-byte update of the bit-parallel NFA of the regex line matcher.
// Depends on slm_pkg; purely combinational.
`default_nettype none

module slm_nfa_step #(
    parameter int PATTERN_MAX = slm_pkg::PATTERN_MAX_DEF
) (
    input  wire slm_pkg::t_cfg        i_cfg,
    input  wire logic [PATTERN_MAX:0] i_active,
    input  wire logic                 i_at_start,
    input  wire logic                 i_found,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_has_byte,
    output logic [PATTERN_MAX:0]      o_active,
    output slm_pkg::t_step_flags      o_flags
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam logic [slm_pkg::LEN_W-1:0] PMAX_L = slm_pkg::LEN_W'(PATTERN_MAX);

    logic [LW-1:0]          len;
    slm_pkg::t_elem         elem [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] star;
    logic                   unanch;
    logic                   tail;
    logic [PATTERN_MAX:0]   cur;
    logic [PATTERN_MAX:0]   adv;
    logic [PATTERN_MAX:0]   nxt;
    logic                   found1;

    // Spread live positions forward across starred elements, drop past len
    function automatic logic [PATTERN_MAX:0] close_set(
        input logic [PATTERN_MAX:0]   set,
        input logic [LW-1:0]          n,
        input logic [PATTERN_MAX-1:0] st
    );
        logic [PATTERN_MAX:0] s;
        s = set;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((LW'(i) < n) && s[i] && st[i]) s[i+1] = 1'b1;
        end
        for (int j = 0; j <= PATTERN_MAX; j++) begin
            if (LW'(j) > n) s[j] = 1'b0;
        end
        return s;
    endfunction

    // Clamp the length and slice out the elements
    assign len = (i_cfg.length > PMAX_L) ? LW'(PATTERN_MAX) : LW'(i_cfg.length);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            elem[k] = slm_pkg::t_elem'(i_cfg.pattern[k*slm_pkg::ELEM_W +: slm_pkg::ELEM_W]);
            star[k] = elem[k].star;
        end
    end

    assign unanch = ~i_cfg.anchor_start;
    assign tail   = i_cfg.anchor_end;

    // Positions live before the byte, with a fresh start where allowed
    assign cur    = close_set(i_active | (PATTERN_MAX+1)'(unanch | i_at_start), len, star);
    assign found1 = i_found | (~tail & cur[len]);

    // Consume the byte: a starred element stays, a plain one moves on
    always_comb begin
        adv = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((LW'(i) < len) && cur[i] && (elem[i].any || (elem[i].ch == i_byte))) begin
                if (elem[i].star) adv[i]   = 1'b1;
                else              adv[i+1] = 1'b1;
            end
        end
    end

    // Result flags and the stored vector
    always_comb begin
        if (i_has_byte) begin
            nxt           = close_set(adv | (PATTERN_MAX+1)'(unanch), len, star);
            o_active      = adv;
            o_flags.found = found1 | (~tail & nxt[len]);
        end else begin
            nxt           = cur;
            o_active      = i_active;
            o_flags.found = found1;
        end
        o_flags.hit = o_flags.found | (tail & nxt[len]);
    end

endmodule

`default_nettype wire

// ===== rtl/simple_regex_line_matcher_top.sv =====
// Regex line matcher: an accepted item is held in the input register and its line result is
// registered in the result register; throughput one byte per cycle while the result register
// can take it, set by the combinational NFA update in between. An output stall holds the input.
// Synchronous active-low reset clears valid flags, matcher state and count; no clearing pass.
// Depends on slm_pkg, slm_cfg_regs, slm_nfa_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module simple_regex_line_matcher_top #(
    parameter int PATTERN_MAX = slm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // text stream in
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,  // [7:0] text_byte
    input  wire logic                           i_s_axis_tuser,  // [0] has_byte
    input  wire logic                           i_s_axis_tlast,  // line_last
    // line results out
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [slm_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,  // [0] line_matched,
                                                                 // [32:1] match_total, rest 0
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [PATTERN_MAX:0] ACT_RESET = (PATTERN_MAX+1)'(1);

    slm_pkg::t_cfg        cfg;
    slm_pkg::t_step_flags flags;
    logic [PATTERN_MAX:0] step_active;

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_has;
    logic                 r_in_last;
    logic [PATTERN_MAX:0] r_active;
    logic                 r_at_start;
    logic                 r_found;
    logic [slm_pkg::COUNT_W-1:0] r_match_total;
    logic [slm_pkg::COUNT_W-1:0] n_match_total;
    logic                 r_out_valid;
    logic                 r_out_matched;
    logic                 r_adv;
    logic                 adv;

    slm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    slm_nfa_step #(.PATTERN_MAX(PATTERN_MAX)) u_step (
        .i_cfg      (cfg),
        .i_active   (r_active),
        .i_at_start (r_at_start),
        .i_found    (r_found),
        .i_byte     (r_in_byte),
        .i_has_byte (r_in_has),
        .o_active   (step_active),
        .o_flags    (flags)
    );

    // The held item moves on when the result register can take it
    assign adv             = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | adv;
    assign n_match_total   = r_match_total + slm_pkg::COUNT_W'(flags.hit);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_has  <= i_s_axis_tuser;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Matcher state; an item with no byte that is not last changes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= ACT_RESET;
            r_at_start    <= 1'b1;
            r_found       <= 1'b0;
            r_match_total <= '0;
        end else if (adv && r_in_last) begin
            r_active      <= ACT_RESET;
            r_at_start    <= 1'b1;
            r_found       <= 1'b0;
            r_match_total <= n_match_total;
        end else if (adv && r_in_has) begin
            r_active      <= step_active;
            r_at_start    <= 1'b0;
            r_found       <= flags.found;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_adv       <= 1'b0;
        end else begin
            r_adv <= adv & r_in_last;
            if (adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_matched <= flags.hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(slm_pkg::OUT_DATA_W-slm_pkg::COUNT_W-1){1'b0}},
                              r_match_total, r_out_matched};

    // A line end always leaves a result and a fresh line state behind
    `ASSERT_NEXT(a_line_end_result, i_clk, i_rst_n, adv && r_in_last, r_out_valid && r_adv)
    `ASSERT_NEXT(a_line_end_clear, i_clk, i_rst_n, adv && r_in_last, (r_active == ACT_RESET) && r_at_start && !r_found)
    // The count only moves with a line end
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !(adv && r_in_last), $stable(r_match_total))
    // An empty input register never blocks the stream
    `ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !r_in_valid, o_s_axis_tready)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for simple_regex_line_matcher_top: directed rows, then random lines.
// Every line result is checked against an in-bench bit-parallel NFA of the pattern or a typed-in expectation.
// Depends on slm_pkg and the matcher RTL only.

module tb_top;
    import slm_pkg::*;

    localparam int ITEM_TARGET   = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 300000;

    // Line result as the block reports it
    typedef struct packed {
        logic        hit;
        logic [31:0] total;
    } line_result_t;

    // One row of the directed stimulus: a register write or a text transfer
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [59:0] val;
        logic [7:0]  text;
        bit          has;
        bit          last;
        bit          typed;
        bit          want_hit;
        logic [31:0] want_total;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Typed-in expectation that travels with the current transfer
    bit          chk_typed = 1'b0;
    bit          chk_hit = 1'b0;
    logic [31:0] chk_total = '0;

    // Predictor copy of configuration and NFA state
    logic [59:0] cfg_lo = '0;
    logic [59:0] cfg_hi = '0;
    logic [3:0]  cfg_len = '0;
    logic        cfg_anc_s = 1'b0;
    logic        cfg_anc_e = 1'b0;
    logic [12:0] nfa_live = 13'd1;
    logic        line_found = 1'b0;
    logic        line_fresh = 1'b1;
    logic [31:0] hit_count = '0;

    line_result_t line_results_q[$];
    stim_row_t    stim_rows[$];

    // Pattern as last programmed by the random generator
    t_elem gen_elems[12];
    int    gen_len = 0;
    bit    gen_anc_s = 1'b0;
    bit    gen_anc_e = 1'b0;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int sent_items = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    simple_regex_line_matcher_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic t_elem elem_at(int k);
        logic [59:0] w;
        int          s;
        w = (k < 6) ? cfg_lo : cfg_hi;
        s = (k < 6) ? k : k - 6;
        return w[10*s +: 10];
    endfunction

    // Starred elements can be skipped: carry live bits across them
    function automatic logic [12:0] nfa_spread(logic [12:0] set, int n);
        t_elem e;
        for (int i = 0; i < n; i++) begin
            e = elem_at(i);
            if (set[i] && e.star)
                set[i+1] = 1'b1;
        end
        for (int i = n + 1; i < 13; i++)
            set[i] = 1'b0;
        return set;
    endfunction

    function automatic logic [12:0] nfa_advance(logic [12:0] set, int n, logic [7:0] text);
        logic [12:0] nxt;
        t_elem       e;
        nxt = '0;
        for (int i = 0; i < n; i++) begin
            e = elem_at(i);
            if (set[i] && (e.any || e.ch == text)) begin
                if (e.star)
                    nxt[i] = 1'b1;
                else
                    nxt[i+1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    // One accepted text transfer; queues the line result when the line ends
    task automatic nfa_consume(logic [7:0] text, logic has, logic last);
        int           n;
        logic [12:0]  cur;
        logic [12:0]  nxt;
        line_result_t res;
        n = (cfg_len > 12) ? 12 : int'(cfg_len);
        if (!has && !last)
            return;
        cur = nfa_live;
        if (!cfg_anc_s || line_fresh)
            cur[0] = 1'b1;
        cur = nfa_spread(cur, n);
        if (!cfg_anc_e && cur[n])
            line_found = 1'b1;
        nxt = cur;
        if (has) begin
            nxt = nfa_advance(cur, n, text);
            nfa_live = nxt;
            line_fresh = 1'b0;
            if (!cfg_anc_s)
                nxt[0] = 1'b1;
            nxt = nfa_spread(nxt, n);
            if (!cfg_anc_e && nxt[n])
                line_found = 1'b1;
        end
        if (!last)
            return;
        res.hit = line_found || (cfg_anc_e && nxt[n]);
        if (res.hit)
            hit_count = hit_count + 32'd1;
        res.total = hit_count;
        if (chk_typed) begin
            res.hit = chk_hit;
            res.total = chk_total;
        end
        line_results_q.push_back(res);
        nfa_live = 13'd1;
        line_found = 1'b0;
        line_fresh = 1'b1;
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // Sample all three channels at the edge; transfers happen where valid and ready meet
    always @(posedge i_clk) begin
        line_result_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PATTERN_LOW:    cfg_lo = i_cfg_data;
                    CFG_PATTERN_HIGH:   cfg_hi = i_cfg_data;
                    CFG_PATTERN_LENGTH: cfg_len = i_cfg_data[3:0];
                    CFG_ANCHOR_START:   cfg_anc_s = i_cfg_data[0];
                    CFG_ANCHOR_END:     cfg_anc_e = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                nfa_consume(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (line_results_q.size() == 0) begin
                    flag_mismatch("line result with none pending", o_m_axis_tdata, 0);
                end else begin
                    want = line_results_q.pop_front();
                    if (o_m_axis_tdata[0] !== want.hit)
                        flag_mismatch("line_matched", o_m_axis_tdata[0], want.hit);
                    if (o_m_axis_tdata[32:1] !== want.total)
                        flag_mismatch("match_total", o_m_axis_tdata[32:1], want.total);
                    if (o_m_axis_tdata[OUT_DATA_W-1:33] !== '0)
                        flag_mismatch("tdata padding", o_m_axis_tdata[OUT_DATA_W-1:33], 0);
                end
            end
        end
    end

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic logic [9:0] pat_elem(logic [7:0] ch, bit any, bit star);
        return {star, any, ch};
    endfunction

    function automatic stim_row_t cfg_row(t_cfg_idx idx, logic [59:0] val);
        stim_row_t r;
        r = '{idx: CFG_PATTERN_LOW, default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic [7:0] text, bit has, bit last);
        stim_row_t r;
        r = '{idx: CFG_PATTERN_LOW, default: '0};
        r.text = text;
        r.has = has;
        r.last = last;
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] text, bit has, bit last, bit hit,
                                            logic [31:0] total);
        stim_row_t r;
        r = item_row(text, has, last);
        r.typed = 1'b1;
        r.want_hit = hit;
        r.want_total = total;
        return r;
    endfunction

    // Mostly the small alphabet so that patterns actually hit
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 75)
            return 8'h61 + 8'($urandom_range(2));
        return 8'($urandom_range(255));
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            1:       begin tx_idle_pct = 46; rx_stall_pct <= 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct <= 46; end
            3:       begin tx_idle_pct = 29; rx_stall_pct <= 29; end
            default: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        endcase
    endtask

    task automatic send_item(logic [7:0] text, bit has, bit last, bit typed = 1'b0,
                             bit hit = 1'b0, logic [31:0] total = '0);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= text;
        i_s_axis_tuser <= has;
        i_s_axis_tlast <= last;
        chk_typed <= typed;
        chk_hit <= hit;
        chk_total <= total;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (has || last)
            sent_items++;
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [59:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let every pending line result drain, then give the pipeline time to settle
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (line_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_pattern();
        logic [59:0] lo;
        logic [59:0] hi;
        int          len;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 0;
        else if (pick < 70)
            len = $urandom_range(1, 5);
        else if (pick < 90)
            len = $urandom_range(6, 12);
        else
            len = $urandom_range(13, 15);
        gen_len = (len > 12) ? 12 : len;
        // unused elements get random junk
        for (int k = 0; k < 12; k++) begin
            if (k < gen_len) begin
                gen_elems[k].ch = pick_char();
                gen_elems[k].any = ($urandom_range(99) < 20);
                gen_elems[k].star = ($urandom_range(99) < 30);
            end else begin
                gen_elems[k] = t_elem'($urandom_range(1023));
            end
        end
        for (int k = 0; k < 6; k++) begin
            lo[10*k +: 10] = gen_elems[k];
            hi[10*k +: 10] = gen_elems[k+6];
        end
        gen_anc_s = $urandom_range(1);
        gen_anc_e = $urandom_range(1);
        cfg_write(CFG_PATTERN_LOW, lo);
        cfg_write(CFG_PATTERN_HIGH, hi);
        cfg_write(CFG_PATTERN_LENGTH, 60'(len));
        cfg_write(CFG_ANCHOR_START, 60'(gen_anc_s));
        cfg_write(CFG_ANCHOR_END, 60'(gen_anc_e));
    endtask

    // Mostly a pattern instance with random padding, sometimes free text
    task automatic make_line(ref logic [7:0] line[$]);
        int reps;
        line.delete();
        if ($urandom_range(99) < 60) begin
            if (!gen_anc_s || $urandom_range(3) == 0)
                repeat ($urandom_range(3)) line.push_back(pick_char());
            for (int k = 0; k < gen_len; k++) begin
                reps = gen_elems[k].star ? $urandom_range(2) : 1;
                repeat (reps)
                    line.push_back(gen_elems[k].any ? pick_char() : gen_elems[k].ch);
            end
            if (!gen_anc_e || $urandom_range(3) == 0)
                repeat ($urandom_range(3)) line.push_back(pick_char());
            // break the instance now and then
            if (line.size() != 0 && $urandom_range(4) == 0)
                line[$urandom_range(line.size() - 1)] = pick_char();
        end else begin
            repeat ($urandom_range(8)) line.push_back(pick_char());
        end
    endtask

    // An empty line goes out as a single transfer without a byte
    task automatic send_line(logic [7:0] line[$], bit end_line);
        if (line.size() == 0) begin
            if (end_line)
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end else begin
            foreach (line[k]) begin
                if ($urandom_range(99) < 5)
                    send_item(8'($urandom_range(255)), 1'b0, 1'b0);
                send_item(line[k], 1'b1, end_line && (k == line.size() - 1));
            end
        end
    endtask

    initial begin
        logic [7:0] line[$];
        int         phase;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the length is zero, so every line matches
        stim_rows.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b1, 32'd1));
        stim_rows.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b1, 32'd2));
        stim_rows.push_back(item_row(8'h5A, 1'b0, 1'b0));
        stim_rows.push_back(typed_row(8'hFF, 1'b1, 1'b1, 1'b1, 32'd3));
        // ^ab*.<NUL>$ : zero byte as a literal, both anchors
        stim_rows.push_back(cfg_row(CFG_PATTERN_LOW, {10'h0, 10'h0, pat_elem(8'h00, 0, 0),
            pat_elem(8'h00, 1, 0), pat_elem("b", 0, 1), pat_elem("a", 0, 0)}));
        stim_rows.push_back(cfg_row(CFG_PATTERN_LENGTH, 60'd4));
        stim_rows.push_back(cfg_row(CFG_ANCHOR_START, 60'd1));
        stim_rows.push_back(cfg_row(CFG_ANCHOR_END, 60'd1));
        stim_rows.push_back(item_row("a", 1'b1, 1'b0));
        stim_rows.push_back(item_row("x", 1'b1, 1'b0));
        stim_rows.push_back(item_row(8'h00, 1'b1, 1'b1));
        stim_rows.push_back(item_row("a", 1'b1, 1'b0));
        stim_rows.push_back(item_row("b", 1'b1, 1'b0));
        stim_rows.push_back(item_row("b", 1'b1, 1'b0));
        stim_rows.push_back(item_row("q", 1'b1, 1'b0));
        stim_rows.push_back(item_row(8'h00, 1'b1, 1'b1));
        stim_rows.push_back(item_row("z", 1'b1, 1'b0));
        stim_rows.push_back(item_row("a", 1'b1, 1'b0));
        stim_rows.push_back(item_row("q", 1'b1, 1'b0));
        stim_rows.push_back(item_row(8'h00, 1'b1, 1'b1));
        stim_rows.push_back(item_row(8'h00, 1'b0, 1'b1));
        // register write in the middle of a line keeps the live positions
        stim_rows.push_back(item_row("a", 1'b1, 1'b0));
        stim_rows.push_back(item_row("b", 1'b1, 1'b0));
        stim_rows.push_back(cfg_row(CFG_ANCHOR_END, 60'd0));
        stim_rows.push_back(item_row("q", 1'b1, 1'b0));
        stim_rows.push_back(item_row(8'h00, 1'b1, 1'b0));
        stim_rows.push_back(item_row("r", 1'b1, 1'b1));
        // all-ones words, last element literal 'z', length above the maximum
        stim_rows.push_back(cfg_row(CFG_PATTERN_LOW, {60{1'b1}}));
        stim_rows.push_back(cfg_row(CFG_PATTERN_HIGH, {pat_elem("z", 0, 0), {50{1'b1}}}));
        stim_rows.push_back(cfg_row(CFG_PATTERN_LENGTH, 60'd15));
        stim_rows.push_back(item_row("z", 1'b1, 1'b1));
        stim_rows.push_back(item_row("y", 1'b1, 1'b1));

        set_idling(0);
        foreach (stim_rows[r]) begin
            if (stim_rows[r].is_cfg) begin
                wait_idle();
                cfg_write(stim_rows[r].idx, stim_rows[r].val);
            end else begin
                send_item(stim_rows[r].text, stim_rows[r].has, stim_rows[r].last,
                          stim_rows[r].typed, stim_rows[r].want_hit, stim_rows[r].want_total);
            end
        end

        // Receiver holds off while the sender keeps pushing short lines
        wait_idle();
        program_pattern();
        hold_req <= 1'b1;
        repeat (30) begin
            make_line(line);
            send_line(line, 1'b1);
        end

        // Random phases, idling pattern rotating; some phases stop mid-line
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            wait_idle();
            program_pattern();
            set_idling(phase % 4);
            repeat ($urandom_range(6, 16)) begin
                make_line(line);
                send_line(line, 1'b1);
            end
            if ($urandom_range(3) == 0) begin
                make_line(line);
                send_line(line, 1'b0);
            end
            phase++;
        end
        wait_idle();

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
